// ===== design/cryg_pkg.sv =====
// shared types, constants and helpers of the camera ray generator
package cryg_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int VEC_FRAC_BITS   = 12;

    localparam int VEC_W      = 21;
    localparam int BND_W      = 16;
    localparam int DIM_W      = 13;
    localparam int DIR_W      = 14;
    localparam int PIX_W      = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int SAT_IN_W   = 48;

    // front: offset = lo + floor((2*span*p + den) / (2*den)), den = n << frac
    localparam int FR_PROD_W  = BND_W + 1 + PIX_W + 1;
    localparam int FR_NUM_S_W = FR_PROD_W + 2;
    localparam int FR_NUM_W   = FR_NUM_S_W - 1;
    localparam int FR_DEN_W   = DIM_W + COORD_FRAC_BITS + 1;
    localparam int FR_Q_W     = 31;

    // back: direction sum, normalization, root and final divide
    localparam int PROD_W      = 2 * VEC_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int NRM_W       = 64;
    localparam int MAG_W       = 30;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SS_W        = SQ_W + 2;
    localparam int SQRT_W      = 64;
    localparam int SQRT_STEPS  = 32;
    localparam int ROOT_W      = 32;
    localparam int DNUM_W      = MAG_W + VEC_FRAC_BITS + 2;
    localparam int DDEN_W      = ROOT_W + 1;
    localparam int DQ_W        = 14;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    localparam logic [3*VEC_W-1:0] AXIS_U_RESET = (3*VEC_W)'(1) << VEC_FRAC_BITS;
    localparam logic [3*VEC_W-1:0] AXIS_V_RESET = (3*VEC_W)'(1) << (VEC_FRAC_BITS + VEC_W);
    localparam logic [3*VEC_W-1:0] AXIS_W_RESET = (3*VEC_W)'(1) << (VEC_FRAC_BITS + 2*VEC_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_POSITION    = 3'd0,
        REG_AXIS_RIGHT      = 3'd1,
        REG_AXIS_UP         = 3'd2,
        REG_AXIS_BACK       = 3'd3,
        REG_VIEWPORT_BOUNDS = 3'd4,
        REG_IMAGE_SIZE      = 3'd5,
        REG_RAY_RANGE       = 3'd6,
        REG_ORTHO_MODE      = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [2:0][VEC_W-1:0] pos;
        logic [2:0][VEC_W-1:0] ax_u;
        logic [2:0][VEC_W-1:0] ax_v;
        logic [2:0][VEC_W-1:0] ax_w;
        logic [3:0][BND_W-1:0] bounds;   // left, right, bottom, top
        logic [DIM_W-1:0]      height;
        logic [DIM_W-1:0]      width;
        logic [VEC_W-1:0]      far_d;
        logic [VEC_W-1:0]      near_d;
        logic                  ortho;
    } t_cfg;

    typedef struct packed {
        logic signed [VEC_W-1:0] u;
        logic signed [VEC_W-1:0] v;
        logic                    oor;
    } t_offset;

    typedef struct packed {
        logic [2:0][VEC_W-1:0] org;
        logic [2:0][DIR_W-1:0] dir;
        logic                  oor;
    } t_ray;

    function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [SAT_IN_W-1:0] x);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = (SAT_IN_W'(1) <<< (VEC_W - 1)) - SAT_IN_W'(1);
        lo = -(SAT_IN_W'(1) <<< (VEC_W - 1));
        if (x > hi) begin
            return hi[VEC_W-1:0];
        end else if (x < lo) begin
            return lo[VEC_W-1:0];
        end
        return x[VEC_W-1:0];
    endfunction

endpackage

// ===== design/cryg_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
module cryg_div_pipe #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 18,
    parameter int Q_W   = 31
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    localparam int CMP_W = DEN_W + Q_W;

    logic [NUM_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];

    for (genvar S = 0; S < Q_W; S++) begin : g_stage
        localparam int B = Q_W - 1 - S;
        logic [NUM_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [Q_W-1:0]   w_quo_in;
        logic [CMP_W-1:0] w_rem_ext;
        logic [CMP_W-1:0] w_trial;

        if (S == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[S-1];
            assign w_den_in = r_den[S-1];
            assign w_quo_in = r_quo[S-1];
        end

        assign w_rem_ext = CMP_W'(w_rem_in);
        assign w_trial   = CMP_W'(w_den_in) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem_ext >= w_trial) begin
                    r_rem[S] <= NUM_W'(w_rem_ext - w_trial);
                    r_quo[S] <= w_quo_in | (Q_W'(1) << B);
                end else begin
                    r_rem[S] <= w_rem_in;
                    r_quo[S] <= w_quo_in;
                end
                r_den[S] <= w_den_in;
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

// ===== design/cryg_isqrt_pipe.sv =====
// pipelined floor integer square root, one result bit per stage
module cryg_isqrt_pipe (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [cryg_pkg::SQRT_W-1:0] i_num,
    output logic [cryg_pkg::ROOT_W-1:0] o_root
);

    localparam int W     = cryg_pkg::SQRT_W;
    localparam int STEPS = cryg_pkg::SQRT_STEPS;

    logic [W-1:0] r_num [STEPS];
    logic [W-1:0] r_res [STEPS];

    for (genvar S = 0; S < STEPS; S++) begin : g_stage
        localparam int SH = 2 * (STEPS - 1 - S);
        logic [W-1:0] w_num_in;
        logic [W-1:0] w_res_in;
        logic [W-1:0] w_bit;
        logic [W-1:0] w_try;

        if (S == 0) begin : g_first
            assign w_num_in = i_num;
            assign w_res_in = '0;
        end else begin : g_next
            assign w_num_in = r_num[S-1];
            assign w_res_in = r_res[S-1];
        end

        assign w_bit = W'(1) << SH;
        assign w_try = w_res_in + w_bit;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_num_in >= w_try) begin
                    r_num[S] <= w_num_in - w_try;
                    r_res[S] <= (w_res_in >> 1) + w_bit;
                end else begin
                    r_num[S] <= w_num_in;
                    r_res[S] <= w_res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[STEPS-1][cryg_pkg::ROOT_W-1:0];

endmodule

// ===== design/cryg_front.sv =====
// front end: takes pixel words, range check and viewport offsets u, v
module cryg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [cryg_pkg::PIX_W-1:0]    i_pixel_x,
    input  logic [cryg_pkg::PIX_W-1:0]    i_pixel_y,
    input  cryg_pkg::t_cfg                i_cfg,
    output logic                          o_valid,
    output cryg_pkg::t_offset             o_ofs
);

    localparam int BW  = cryg_pkg::BND_W;
    localparam int PW  = cryg_pkg::FR_PROD_W;
    localparam int NSW = cryg_pkg::FR_NUM_S_W;
    localparam int NW  = cryg_pkg::FR_NUM_W;
    localparam int DW  = cryg_pkg::FR_DEN_W;
    localparam int QW  = cryg_pkg::FR_Q_W;
    localparam int CF  = cryg_pkg::COORD_FRAC_BITS;
    localparam int SW  = cryg_pkg::SAT_IN_W;

    typedef struct packed {
        logic signed [BW-1:0] lo_x;
        logic signed [BW-1:0] lo_y;
        logic                 nz_x;
        logic                 nz_y;
        logic                 neg_x;
        logic                 neg_y;
        logic                 oor;
    } t_fside;

    // stage a: span times coordinate
    logic signed [BW-1:0] w_lo_x, w_hi_x, w_lo_y, w_hi_y;
    logic signed [BW:0]   w_span_x, w_span_y;
    logic signed [PW-1:0] w_prod_x, w_prod_y;
    logic                 w_oor;

    assign w_lo_x   = i_cfg.bounds[0];
    assign w_hi_x   = i_cfg.bounds[1];
    assign w_lo_y   = i_cfg.bounds[2];
    assign w_hi_y   = i_cfg.bounds[3];
    assign w_span_x = (BW+1)'(w_hi_x) - (BW+1)'(w_lo_x);
    assign w_span_y = (BW+1)'(w_hi_y) - (BW+1)'(w_lo_y);
    assign w_prod_x = w_span_x * $signed({1'b0, i_pixel_x});
    assign w_prod_y = w_span_y * $signed({1'b0, i_pixel_y});
    assign w_oor    = ((i_pixel_x >> CF) >= cryg_pkg::PIX_W'(i_cfg.width)) ||
                      ((i_pixel_y >> CF) >= cryg_pkg::PIX_W'(i_cfg.height));

    logic                 r_a_vld;
    logic signed [PW-1:0] r_a_prod_x, r_a_prod_y;
    logic                 r_a_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_prod_x <= w_prod_x;
            r_a_prod_y <= w_prod_y;
            r_a_oor    <= w_oor;
        end
    end

    // stage b: numerator magnitude for floor division
    logic [DW-2:0]  w_den_x, w_den_y;
    logic [DW-1:0]  w_dd_x, w_dd_y;
    logic [NSW-1:0] w_n_x, w_n_y;
    logic           w_neg_x, w_neg_y;
    logic [NW-1:0]  w_mag_x, w_mag_y;

    assign w_den_x = (DW-1)'(i_cfg.width) << CF;
    assign w_den_y = (DW-1)'(i_cfg.height) << CF;
    assign w_dd_x  = DW'(w_den_x) << 1;
    assign w_dd_y  = DW'(w_den_y) << 1;
    assign w_n_x   = (NSW'(r_a_prod_x) << 1) + NSW'(w_den_x);
    assign w_n_y   = (NSW'(r_a_prod_y) << 1) + NSW'(w_den_y);
    assign w_neg_x = w_n_x[NSW-1];
    assign w_neg_y = w_n_y[NSW-1];
    // -n + d - 1 is ~n + d
    assign w_mag_x = NW'(w_neg_x ? (~w_n_x + NSW'(w_dd_x)) : w_n_x);
    assign w_mag_y = NW'(w_neg_y ? (~w_n_y + NSW'(w_dd_y)) : w_n_y);

    logic          r_b_vld;
    logic [NW-1:0] r_b_mag_x, r_b_mag_y;
    t_fside        r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_mag_x      <= w_mag_x;
            r_b_mag_y      <= w_mag_y;
            r_b_side.lo_x  <= w_lo_x;
            r_b_side.lo_y  <= w_lo_y;
            r_b_side.nz_x  <= (i_cfg.width != '0);
            r_b_side.nz_y  <= (i_cfg.height != '0);
            r_b_side.neg_x <= w_neg_x;
            r_b_side.neg_y <= w_neg_y;
            r_b_side.oor   <= r_a_oor;
        end
    end

    // dividers and matching side line
    logic [QW-1:0] w_q_x, w_q_y;

    cryg_div_pipe #(.NUM_W(NW), .DEN_W(DW), .Q_W(QW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_b_mag_x),
        .i_den (w_dd_x),
        .o_quo (w_q_x)
    );

    cryg_div_pipe #(.NUM_W(NW), .DEN_W(DW), .Q_W(QW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_b_mag_y),
        .i_den (w_dd_y),
        .o_quo (w_q_y)
    );

    logic [QW-1:0] r_dv;
    t_fside        r_ds [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (i_en) begin
            r_dv <= {r_dv[QW-2:0], r_b_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ds[0] <= r_b_side;
            for (int s = 1; s < QW; s++) begin
                r_ds[s] <= r_ds[s-1];
            end
        end
    end

    // stage c: signed quotient, add lower bound, saturate
    t_fside                w_fs;
    logic signed [QW:0]    w_qs_x, w_qs_y;
    logic signed [SW-1:0]  w_sum_x, w_sum_y;
    logic signed [cryg_pkg::VEC_W-1:0] w_u, w_v;

    assign w_fs    = r_ds[QW-1];
    assign w_qs_x  = w_fs.neg_x ? -$signed({1'b0, w_q_x}) : $signed({1'b0, w_q_x});
    assign w_qs_y  = w_fs.neg_y ? -$signed({1'b0, w_q_y}) : $signed({1'b0, w_q_y});
    assign w_sum_x = SW'(w_fs.lo_x) + SW'(w_qs_x);
    assign w_sum_y = SW'(w_fs.lo_y) + SW'(w_qs_y);
    assign w_u     = w_fs.nz_x ? cryg_pkg::sat_vec(w_sum_x) : cryg_pkg::VEC_W'(w_fs.lo_x);
    assign w_v     = w_fs.nz_y ? cryg_pkg::sat_vec(w_sum_y) : cryg_pkg::VEC_W'(w_fs.lo_y);

    logic              r_c_vld;
    cryg_pkg::t_offset r_c_ofs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_dv[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_ofs.u   <= w_u;
            r_c_ofs.v   <= w_v;
            r_c_ofs.oor <= w_fs.oor;
        end
    end

    assign o_valid = r_c_vld;
    assign o_ofs   = r_c_ofs;

endmodule

// ===== design/cryg_queue.sv =====
// short fifo between front end and back end
module cryg_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cryg_pkg::t_offset i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output cryg_pkg::t_offset o_data
);

    localparam int DEPTH = cryg_pkg::QUEUE_DEPTH;
    localparam int PW    = cryg_pkg::QUEUE_PTR_W;

    cryg_pkg::t_offset r_mem [DEPTH];
    logic [PW-1:0]     r_wr, r_rd;
    logic [PW:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule

// ===== design/cryg_back.sv =====
// back end: direction sum, normalization and ray assembly
module cryg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cryg_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  cryg_pkg::t_offset i_ofs,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output cryg_pkg::t_ray    o_ray
);

    localparam int VW  = cryg_pkg::VEC_W;
    localparam int PRW = cryg_pkg::PROD_W;
    localparam int SMW = cryg_pkg::SUM_W;
    localparam int NRW = cryg_pkg::NRM_W;
    localparam int MW  = cryg_pkg::MAG_W;
    localparam int SQW = cryg_pkg::SQ_W;
    localparam int SSW = cryg_pkg::SS_W;
    localparam int RW  = cryg_pkg::ROOT_W;
    localparam int DNW = cryg_pkg::DNUM_W;
    localparam int DDW = cryg_pkg::DDEN_W;
    localparam int DQW = cryg_pkg::DQ_W;
    localparam int DRW = cryg_pkg::DIR_W;
    localparam int F   = cryg_pkg::VEC_FRAC_BITS;
    localparam int SW  = cryg_pkg::SAT_IN_W;
    localparam int STP = cryg_pkg::SQRT_STEPS;
    localparam int NST = 6;

    typedef struct packed {
        logic [2:0][VW-1:0] org;
        logic [2:0]         neg;
        logic               zero;
        logic               oor;
    } t_rside;

    typedef struct packed {
        t_rside             rs;
        logic [2:0][MW-1:0] a;
    } t_qside;

    logic w_en;
    assign w_en  = !o_valid || i_ready;
    assign o_pop = w_en && i_valid;

    // stage p: offset times axes
    logic                  r_p_vld;
    logic signed [PRW-1:0] r_p_pu [3];
    logic signed [PRW-1:0] r_p_pv [3];
    logic                  r_p_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_en) begin
            r_p_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p_pu[i] <= i_ofs.u * $signed(i_cfg.ax_u[i]);
                r_p_pv[i] <= i_ofs.v * $signed(i_cfg.ax_v[i]);
            end
            r_p_oor <= i_ofs.oor;
        end
    end

    // stage s: add the base term (position or -w, scaled by one)
    logic                  r_s_vld;
    logic signed [SMW-1:0] r_s_sum [3];
    logic                  r_s_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (w_en) begin
            r_s_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [SMW-1:0] base;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                base = i_cfg.ortho ? SMW'($signed(i_cfg.pos[i])) :
                                     -SMW'($signed(i_cfg.ax_w[i]));
                r_s_sum[i] <= (base <<< F) + SMW'(r_p_pu[i]) + SMW'(r_p_pv[i]);
            end
            r_s_oor <= r_p_oor;
        end
    end

    // stage a: origin, direction magnitudes and signs
    logic                  r_a_vld;
    logic [SMW-1:0]        r_a_mag [3];
    t_rside                r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [SMW-1:0] rnd;
        logic signed [SMW-1:0] d;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                rnd = (r_s_sum[i] + (SMW'(1) <<< (F - 1))) >>> F;
                d   = i_cfg.ortho ? -SMW'($signed(i_cfg.ax_w[i])) : r_s_sum[i];
                r_a_side.org[i] <= i_cfg.ortho ? cryg_pkg::sat_vec(SW'(rnd)) : i_cfg.pos[i];
                r_a_side.neg[i] <= d[SMW-1];
                r_a_mag[i]      <= d[SMW-1] ? SMW'(-d) : SMW'(d);
            end
            r_a_side.zero <= 1'b0;
            r_a_side.oor  <= r_s_oor;
        end
    end

    // stage m: largest magnitude
    logic           r_m_vld;
    logic [NRW-1:0] r_m_a [3];
    logic [NRW-1:0] r_m_max;
    t_rside         r_m_side;
    logic [SMW-1:0] w_m01, w_max;

    assign w_m01 = (r_a_mag[0] > r_a_mag[1]) ? r_a_mag[0] : r_a_mag[1];
    assign w_max = (w_m01 > r_a_mag[2]) ? w_m01 : r_a_mag[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m_a[i] <= NRW'(r_a_mag[i]);
            end
            r_m_max       <= NRW'(w_max);
            r_m_side.org  <= r_a_side.org;
            r_m_side.neg  <= r_a_side.neg;
            r_m_side.oor  <= r_a_side.oor;
            r_m_side.zero <= (w_max == '0);
        end
    end

    // normalize stages: left-justify the largest magnitude, 32/16/8/4/2/1
    logic [NST-1:0] r_n_vld;
    logic [NRW-1:0] r_n_a   [NST][3];
    logic [NRW-1:0] r_n_max [NST];
    t_rside         r_n_side [NST];

    for (genvar S = 0; S < NST; S++) begin : g_nrm
        localparam int K = (NRW / 2) >> S;
        logic           w_vin;
        logic [NRW-1:0] w_ain [3];
        logic [NRW-1:0] w_min;
        t_rside         w_sin;
        logic           w_sh;

        if (S == 0) begin : g_first
            assign w_vin = r_m_vld;
            assign w_ain = r_m_a;
            assign w_min = r_m_max;
            assign w_sin = r_m_side;
        end else begin : g_next
            assign w_vin = r_n_vld[S-1];
            assign w_ain = r_n_a[S-1];
            assign w_min = r_n_max[S-1];
            assign w_sin = r_n_side[S-1];
        end

        assign w_sh = (w_min[NRW-1 -: K] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_n_vld[S] <= 1'b0;
            end else if (w_en) begin
                r_n_vld[S] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_n_a[S][i] <= w_sh ? (w_ain[i] << K) : w_ain[i];
                end
                r_n_max[S]  <= w_sh ? (w_min << K) : w_min;
                r_n_side[S] <= w_sin;
            end
        end
    end

    // stage q: squares of the scaled magnitudes, largest now in [2^29, 2^30)
    logic           r_q_vld;
    logic [SQW-1:0] r_q_sq [3];
    t_qside         r_q_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (w_en) begin
            r_q_vld <= r_n_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [MW-1:0] a;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                a = r_n_a[NST-1][i][NRW-1 -: MW];
                r_q_sq[i]     <= SQW'(a) * SQW'(a);
                r_q_side.a[i] <= a;
            end
            r_q_side.rs <= r_n_side[NST-1];
        end
    end

    // stage t: sum of squares
    logic           r_t_vld;
    logic [SSW-1:0] r_t_ss;
    t_qside         r_t_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (w_en) begin
            r_t_vld <= r_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_ss   <= SSW'(r_q_sq[0]) + SSW'(r_q_sq[1]) + SSW'(r_q_sq[2]);
            r_t_side <= r_q_side;
        end
    end

    // root and matching side line
    logic [RW-1:0] w_root;

    cryg_isqrt_pipe u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (cryg_pkg::SQRT_W'(r_t_ss)),
        .o_root (w_root)
    );

    logic [STP-1:0] r_rv;
    t_qside         r_rs [STP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
        end else if (w_en) begin
            r_rv <= {r_rv[STP-2:0], r_t_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rs[0] <= r_t_side;
            for (int s = 1; s < STP; s++) begin
                r_rs[s] <= r_rs[s-1];
            end
        end
    end

    // stage d: rounded quotient operands (a * 2^(f+1) + n) / 2n
    logic           r_d_vld;
    logic [DNW-1:0] r_d_num [3];
    logic [DDW-1:0] r_d_den;
    t_rside         r_d_side;
    t_qside         w_rq;

    assign w_rq = r_rs[STP-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= r_rv[STP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d_num[i] <= (DNW'(w_rq.a[i]) << (F + 1)) + DNW'(w_root);
            end
            r_d_den  <= DDW'(w_root) << 1;
            r_d_side <= w_rq.rs;
        end
    end

    logic [DQW-1:0] w_q [3];

    for (genvar I = 0; I < 3; I++) begin : g_div
        cryg_div_pipe #(.NUM_W(DNW), .DEN_W(DDW), .Q_W(DQW)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_d_num[I]),
            .i_den (r_d_den),
            .o_quo (w_q[I])
        );
    end

    logic [DQW-1:0] r_dv;
    t_rside         r_ds [DQW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (w_en) begin
            r_dv <= {r_dv[DQW-2:0], r_d_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ds[0] <= r_d_side;
            for (int s = 1; s < DQW; s++) begin
                r_ds[s] <= r_ds[s-1];
            end
        end
    end

    // output register
    logic           r_o_vld;
    cryg_pkg::t_ray r_o_ray;
    t_rside         w_os;

    assign w_os = r_ds[DQW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= r_dv[DQW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_o_ray.org[i] <= w_os.org[i];
                if (w_os.zero) begin
                    r_o_ray.dir[i] <= '0;
                end else if (w_os.neg[i]) begin
                    r_o_ray.dir[i] <= DRW'(-w_q[i]);
                end else begin
                    r_o_ray.dir[i] <= DRW'(w_q[i]);
                end
            end
            r_o_ray.oor <= w_os.oor;
        end
    end

    assign o_valid = r_o_vld;
    assign o_ray   = r_o_ray;

endmodule

// ===== design/camera_ray_generator_core.sv =====
// top level of the camera ray generator: config registers, front, queue, back
//
// One primary ray per pixel word. A pixel coordinate (unsigned 12.4) is mapped onto
// the viewport as u, v; perspective mode gives origin = camera position and direction
// = normalized(-w + u*U + v*V), orthographic mode gives direction = normalized(-w) and
// origin = position + u*U + v*V, saturated Q8.12. Near/far are copied from the config
// register, and out_of_range flags a coordinate whose integer part reaches the image
// width or height (the ray is still extrapolated). The block takes one word per clock
// and delivers one ray per clock when the output side keeps up. The front end has two
// 31-step offset dividers, the queue registers each word, and the back end has a
// 32-step square root and 14-step direction dividers. The queue holds four words so
// front and back stall independently. Write config only while the block is empty.
module camera_ray_generator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [cryg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cryg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // pixel words
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [31:0]                        i_s_axis_tdata,   // pixel_x, pixel_y
    // ray words
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, range_near, range_far, zero pad
    output logic [151:0]                       o_m_axis_tdata,
    output logic                               o_m_axis_tuser    // out_of_range
);

    localparam int VW = cryg_pkg::VEC_W;
    localparam int DW = cryg_pkg::DIM_W;

    // config registers
    cryg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos    <= '0;
            r_cfg.ax_u   <= cryg_pkg::AXIS_U_RESET;
            r_cfg.ax_v   <= cryg_pkg::AXIS_V_RESET;
            r_cfg.ax_w   <= cryg_pkg::AXIS_W_RESET;
            r_cfg.bounds <= '0;
            r_cfg.width  <= '0;
            r_cfg.height <= '0;
            r_cfg.near_d <= '0;
            r_cfg.far_d  <= '0;
            r_cfg.ortho  <= 1'b0;
        end else if (i_cfg_we) begin
            case (cryg_pkg::t_cfg_index'(i_cfg_index))
                cryg_pkg::REG_CAM_POSITION:    r_cfg.pos    <= i_cfg_data[3*VW-1:0];
                cryg_pkg::REG_AXIS_RIGHT:      r_cfg.ax_u   <= i_cfg_data[3*VW-1:0];
                cryg_pkg::REG_AXIS_UP:         r_cfg.ax_v   <= i_cfg_data[3*VW-1:0];
                cryg_pkg::REG_AXIS_BACK:       r_cfg.ax_w   <= i_cfg_data[3*VW-1:0];
                cryg_pkg::REG_VIEWPORT_BOUNDS: r_cfg.bounds <= i_cfg_data;
                cryg_pkg::REG_IMAGE_SIZE: begin
                    r_cfg.width  <= i_cfg_data[DW-1:0];
                    r_cfg.height <= i_cfg_data[2*DW-1:DW];
                end
                cryg_pkg::REG_RAY_RANGE: begin
                    r_cfg.near_d <= i_cfg_data[VW-1:0];
                    r_cfg.far_d  <= i_cfg_data[2*VW-1:VW];
                end
                cryg_pkg::REG_ORTHO_MODE:      r_cfg.ortho  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front end freezes when the queue is full
    logic              w_q_full;
    logic              w_f_en;
    logic              w_f_vld;
    cryg_pkg::t_offset w_f_ofs;

    assign w_f_en          = !w_q_full;
    assign o_s_axis_tready = w_f_en;

    cryg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_f_en),
        .i_valid   (i_s_axis_tvalid),
        .i_pixel_x (i_s_axis_tdata[15:0]),
        .i_pixel_y (i_s_axis_tdata[31:16]),
        .i_cfg     (r_cfg),
        .o_valid   (w_f_vld),
        .o_ofs     (w_f_ofs)
    );

    // offsets waiting for the back end
    logic              w_q_vld;
    logic              w_q_pop;
    cryg_pkg::t_offset w_q_ofs;

    cryg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_en && w_f_vld),
        .i_data  (w_f_ofs),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_vld),
        .o_data  (w_q_ofs)
    );

    cryg_pkg::t_ray w_ray;

    cryg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_vld),
        .i_ofs   (w_q_ofs),
        .o_pop   (w_q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_ray   (w_ray)
    );

    // near/far come from config; user must hold it while rays are in flight, unenforced
    assign o_m_axis_tdata = {5'b0, r_cfg.far_d, r_cfg.near_d,
                             w_ray.dir[2], w_ray.dir[1], w_ray.dir[0],
                             w_ray.org[2], w_ray.org[1], w_ray.org[0]};
    assign o_m_axis_tuser = w_ray.oor;

endmodule
